// ===== rtl/core/elevator_scan_controller_core_defines.svh =====
// assertion helpers shared by the elevator scan controller modules
`ifndef ELEVATOR_SCAN_CONTROLLER_CORE_DEFINES_SVH
`define ELEVATOR_SCAN_CONTROLLER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define ESC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("elevator scan controller: same-cycle check failed");
`define ESC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("elevator scan controller: next-cycle check failed");
`else
`define ESC_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ESC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/core/esc_pkg.sv =====
`default_nettype none

package esc_pkg;

    localparam int MAX_FLOORS = 16;
    localparam int FLOOR_W    = 5;
    localparam int IDX_W      = $clog2(MAX_FLOORS);
    localparam int TYPE_W     = 2;
    localparam int CODE_W     = 3;

    localparam logic [FLOOR_W-1:0] TOP_FLOOR_RESET = FLOOR_W'(13);
    localparam logic [FLOOR_W-1:0] FIRST_FLOOR     = FLOOR_W'(1);

    typedef enum logic [TYPE_W-1:0] {
        REQ_CALL    = 2'd0,
        REQ_MOVED   = 2'd1,
        REQ_CLOSING = 2'd2,
        REQ_CLOSED  = 2'd3
    } req_type_t;

    typedef enum logic [CODE_W-1:0] {
        MODE_STAYING = 3'd0,
        MODE_OPENING = 3'd1,
        MODE_CLOSING = 3'd2,
        MODE_SOLVING = 3'd3,
        MODE_RUNNING = 3'd4
    } mode_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_CHECK,
        S_SCAN_SECOND,
        S_EMIT_RESULT,
        S_EMIT_SOLVING,
        S_EMIT_LAST
    } ctrl_state_t;

    typedef struct packed {
        logic      capture;
        logic      set_call;
        logic      clear_cabin;
        logic      flip_dir;
        logic      step_cabin;
        logic      set_mode;
        mode_t     mode_val;
        logic      emit;
        logic      emit_solving;
        logic      emit_last;
    } dp_cmd_t;

    typedef struct packed {
        req_type_t req_type;
        logic      call_ok;
        mode_t     mode;
        logic      cabin_called;
        logic      scan_hit;
        logic      out_free;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/esc_if.sv =====
`default_nettype none

interface esc_req_if;
    logic                            valid;
    logic                            ready;
    logic [esc_pkg::TYPE_W-1:0]      req_type;
    logic [esc_pkg::FLOOR_W-1:0]     call_floor;

    modport source (output valid, output req_type, output call_floor, input ready);
    modport sink   (input valid, input req_type, input call_floor, output ready);
endinterface

interface esc_evt_if;
    logic                            valid;
    logic                            ready;
    logic [esc_pkg::CODE_W-1:0]      event_code;
    logic [esc_pkg::FLOOR_W-1:0]     cabin_floor_out;
    logic                            direction_up;
    logic                            last_of_run;

    modport source (output valid, output event_code, output cabin_floor_out,
                    output direction_up, output last_of_run, input ready);
    modport sink   (input valid, input event_code, input cabin_floor_out,
                    input direction_up, input last_of_run, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/esc_datapath.sv =====
`default_nettype none

`include "elevator_scan_controller_core_defines.svh"

module esc_datapath (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [esc_pkg::FLOOR_W-1:0] cfg_data,
    input  wire logic [esc_pkg::TYPE_W-1:0]  in_req_type,
    input  wire logic [esc_pkg::FLOOR_W-1:0] in_call_floor,
    input  wire esc_pkg::dp_cmd_t            cmd,
    output esc_pkg::dp_status_t              status,
    esc_evt_if.source                        evt
);

    logic [esc_pkg::TYPE_W-1:0]     req_type_reg;
    logic [esc_pkg::FLOOR_W-1:0]    call_floor_reg;
    logic [esc_pkg::FLOOR_W-1:0]    top_floor_reg;
    esc_pkg::mode_t                 mode_reg;
    logic [esc_pkg::MAX_FLOORS-1:0] call_bits_reg;
    logic [esc_pkg::MAX_FLOORS-1:0] call_bits_next;
    logic [esc_pkg::FLOOR_W-1:0]    cabin_reg;
    logic                           going_up_reg;

    logic                           out_valid_reg;
    logic [esc_pkg::CODE_W-1:0]     out_code_reg;
    logic [esc_pkg::FLOOR_W-1:0]    out_floor_reg;
    logic                           out_up_reg;
    logic                           out_last_reg;

    logic [esc_pkg::FLOOR_W-1:0]    scan_top;
    logic [esc_pkg::IDX_W-1:0]      cabin_idx;
    logic [esc_pkg::IDX_W-1:0]      call_idx;
    logic [esc_pkg::MAX_FLOORS-1:0] scan_mask;
    logic                           out_free;

    // calls and the upward scan stop at the lower of top_floor and the building height
    assign scan_top  = (32'(top_floor_reg) > esc_pkg::MAX_FLOORS)
                       ? esc_pkg::FLOOR_W'(esc_pkg::MAX_FLOORS) : top_floor_reg;
    assign cabin_idx = esc_pkg::IDX_W'(cabin_reg - esc_pkg::FIRST_FLOOR);
    assign call_idx  = esc_pkg::IDX_W'(call_floor_reg - esc_pkg::FIRST_FLOOR);
    assign out_free  = !out_valid_reg || evt.ready;

    // floors ahead of the cabin in the current direction, cabin floor included
    always_comb
    begin
        for (int i = 0; i < esc_pkg::MAX_FLOORS; i++)
        begin
            if (going_up_reg)
                scan_mask[i] = (esc_pkg::FLOOR_W'(i + 1) >= cabin_reg) &&
                               (esc_pkg::FLOOR_W'(i + 1) <= scan_top);
            else
                scan_mask[i] = (esc_pkg::FLOOR_W'(i + 1) <= cabin_reg);
        end
    end

    always_comb
    begin
        status.req_type     = esc_pkg::req_type_t'(req_type_reg);
        status.call_ok      = (call_floor_reg >= esc_pkg::FIRST_FLOOR) &&
                              (call_floor_reg <= scan_top);
        status.mode         = mode_reg;
        status.cabin_called = call_bits_reg[cabin_idx];
        status.scan_hit     = |(call_bits_reg & scan_mask);
        status.out_free     = out_free;
    end

    always_comb
    begin
        call_bits_next = call_bits_reg;
        if (cmd.set_call)
            call_bits_next[call_idx] = 1'b1;
        if (cmd.clear_cabin)
            call_bits_next[cabin_idx] = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_floor_reg <= esc_pkg::TOP_FLOOR_RESET;
            mode_reg      <= esc_pkg::MODE_STAYING;
            call_bits_reg <= '0;
            cabin_reg     <= esc_pkg::FIRST_FLOOR;
            going_up_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                top_floor_reg <= cfg_data;
            if (cmd.set_mode)
                mode_reg <= cmd.mode_val;
            call_bits_reg <= call_bits_next;
            if (cmd.flip_dir)
                going_up_reg <= !going_up_reg;
            if (cmd.step_cabin)
                cabin_reg <= going_up_reg ? cabin_reg + esc_pkg::FIRST_FLOOR
                                          : cabin_reg - esc_pkg::FIRST_FLOOR;
            if (cmd.emit && out_free)
                out_valid_reg <= 1'b1;
            else if (evt.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_type_reg   <= in_req_type;
            call_floor_reg <= in_call_floor;
        end
        if (cmd.emit && out_free)
        begin
            out_code_reg  <= cmd.emit_solving ? esc_pkg::MODE_SOLVING : mode_reg;
            out_floor_reg <= cabin_reg;
            out_up_reg    <= going_up_reg;
            out_last_reg  <= cmd.emit_last;
        end
    end

    assign evt.valid           = out_valid_reg;
    assign evt.event_code      = out_code_reg;
    assign evt.cabin_floor_out = out_floor_reg;
    assign evt.direction_up    = out_up_reg;
    assign evt.last_of_run     = out_last_reg;

    `ESC_ASSERT_IMPL(a_cabin_in_building, clk, rst_n, 1'b1, (cabin_reg >= esc_pkg::FIRST_FLOOR) && (32'(cabin_reg) <= esc_pkg::MAX_FLOORS))
    `ESC_ASSERT_IMPL(a_step_needs_hit, clk, rst_n, cmd.step_cabin, status.scan_hit && !status.cabin_called)
    `ESC_ASSERT_NEXT(a_step_moves_cabin, clk, rst_n, cmd.step_cabin, cabin_reg != $past(cabin_reg))

endmodule

`default_nettype wire

// ===== rtl/core/esc_ctrl.sv =====
`default_nettype none

`include "elevator_scan_controller_core_defines.svh"

module esc_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire esc_pkg::dp_status_t status,
    output esc_pkg::dp_cmd_t         cmd
);

    esc_pkg::ctrl_state_t state_reg;
    esc_pkg::ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= esc_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        cmd.mode_val = esc_pkg::MODE_STAYING;

        unique case (state_reg)
            esc_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = esc_pkg::S_DECODE;
                end
            end

            esc_pkg::S_DECODE:
            begin
                state_next = esc_pkg::S_IDLE;
                unique case (status.req_type)
                    esc_pkg::REQ_CALL:
                    begin
                        if (status.call_ok)
                        begin
                            cmd.set_call = 1'b1;
                            if (status.mode == esc_pkg::MODE_STAYING)
                                state_next = esc_pkg::S_CHECK;
                        end
                    end
                    esc_pkg::REQ_CLOSING:
                    begin
                        if (status.mode == esc_pkg::MODE_OPENING)
                        begin
                            cmd.set_mode = 1'b1;
                            cmd.mode_val = esc_pkg::MODE_CLOSING;
                            state_next   = esc_pkg::S_EMIT_LAST;
                        end
                    end
                    esc_pkg::REQ_MOVED, esc_pkg::REQ_CLOSED:
                    begin
                        if (status.mode == esc_pkg::MODE_STAYING ||
                            status.mode == esc_pkg::MODE_CLOSING ||
                            status.mode == esc_pkg::MODE_RUNNING)
                            state_next = esc_pkg::S_CHECK;
                    end
                endcase
            end

            // cabin floor called, else first scan pass in the current direction
            esc_pkg::S_CHECK:
            begin
                cmd.set_mode = 1'b1;
                if (status.cabin_called)
                begin
                    cmd.clear_cabin = 1'b1;
                    cmd.mode_val    = esc_pkg::MODE_OPENING;
                    state_next      = esc_pkg::S_EMIT_RESULT;
                end
                else if (status.scan_hit)
                begin
                    cmd.step_cabin = 1'b1;
                    cmd.mode_val   = esc_pkg::MODE_RUNNING;
                    state_next     = esc_pkg::S_EMIT_RESULT;
                end
                else
                begin
                    cmd.flip_dir = 1'b1;
                    cmd.mode_val = esc_pkg::MODE_SOLVING;
                    state_next   = esc_pkg::S_SCAN_SECOND;
                end
            end

            // reversed direction; a miss flips back and the cabin rests
            esc_pkg::S_SCAN_SECOND:
            begin
                cmd.set_mode = 1'b1;
                state_next   = esc_pkg::S_EMIT_RESULT;
                if (status.scan_hit)
                begin
                    cmd.step_cabin = 1'b1;
                    cmd.mode_val   = esc_pkg::MODE_RUNNING;
                end
                else
                begin
                    cmd.flip_dir = 1'b1;
                    cmd.mode_val = esc_pkg::MODE_STAYING;
                end
            end

            esc_pkg::S_EMIT_RESULT:
            begin
                cmd.emit = 1'b1;
                if (status.out_free)
                    state_next = esc_pkg::S_EMIT_SOLVING;
            end

            esc_pkg::S_EMIT_SOLVING:
            begin
                cmd.emit         = 1'b1;
                cmd.emit_solving = 1'b1;
                cmd.emit_last    = 1'b1;
                if (status.out_free)
                    state_next = esc_pkg::S_IDLE;
            end

            esc_pkg::S_EMIT_LAST:
            begin
                cmd.emit      = 1'b1;
                cmd.emit_last = 1'b1;
                if (status.out_free)
                    state_next = esc_pkg::S_IDLE;
            end

            default:
            begin
                state_next = esc_pkg::S_IDLE;
            end
        endcase
    end

    `ESC_ASSERT_IMPL(a_solving_follows_result, clk, rst_n, state_reg == esc_pkg::S_EMIT_SOLVING, $past(state_reg) == esc_pkg::S_EMIT_RESULT || $past(state_reg) == esc_pkg::S_EMIT_SOLVING)
    `ESC_ASSERT_NEXT(a_second_pass_ends, clk, rst_n, state_reg == esc_pkg::S_SCAN_SECOND, state_reg == esc_pkg::S_EMIT_RESULT && status.mode != esc_pkg::MODE_SOLVING)

endmodule

`default_nettype wire

// ===== rtl/core/elevator_scan_controller_core.sv =====
// an input transaction is captured and decoded, then checked for a call at the cabin floor, else
// scanned ahead (a second pass when the scan reverses) before the first result is registered;
// doors closing goes from decode straight to its result. A new event is taken only in idle, after
// the controller sequence of decode, cabin check, up to two scan passes and two result transactions
// a result waits in an output register while the next event is taken
// reset (async, active low): staying, no calls, cabin at floor 1, up, top_floor 13, no result
`default_nettype none

module elevator_scan_controller_core (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [esc_pkg::FLOOR_W-1:0] cfg_data,
    esc_req_if.sink                          req,
    esc_evt_if.source                        evt
);

    esc_pkg::dp_cmd_t    cmd;
    esc_pkg::dp_status_t status;

    esc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .status   (status),
        .cmd      (cmd)
    );

    esc_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data),
        .in_req_type   (req.req_type),
        .in_call_floor (req.call_floor),
        .cmd           (cmd),
        .status        (status),
        .evt           (evt)
    );

endmodule

`default_nettype wire

// ===== dv/tb_elevator_scan_controller_core.sv =====
`default_nettype none

module tb_elevator_scan_controller_core;
    timeunit 1ns;
    timeprecision 1ps;

    import esc_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 12;
    localparam int PHASE_ITEMS  = 190;
    localparam int NUM_PHASES   = 8;

    typedef struct {
        mode_t              code;
        logic [FLOOR_W-1:0] floor;
        logic               up;
        logic               last;
    } floor_event_t;

    class elevator_tracker;
        mode_t                 mode;
        logic [MAX_FLOORS-1:0] calls;
        logic [FLOOR_W-1:0]    cabin;
        logic                  going_up;
        logic [FLOOR_W-1:0]    top_floor;
        floor_event_t          pending[$];
        int                    errors;

        function new();
            mode      = MODE_STAYING;
            calls     = '0;
            cabin     = FIRST_FLOOR;
            going_up  = 1'b1;
            top_floor = TOP_FLOOR_RESET;
            errors    = 0;
        endfunction

        function int scan_limit();
            return (top_floor < MAX_FLOORS) ? int'(top_floor) : MAX_FLOORS;
        endfunction

        function bit called(int f);
            if (f < 1 || f > MAX_FLOORS)
            begin
                return 1'b0;
            end
            return calls[f-1];
        endfunction

        function bit scan_ahead();
            if (going_up)
            begin
                for (int f = cabin; f <= scan_limit(); f++)
                begin
                    if (called(f))
                    begin
                        return 1'b1;
                    end
                end
            end
            else
            begin
                for (int f = cabin; f >= 1; f--)
                begin
                    if (called(f))
                    begin
                        return 1'b1;
                    end
                end
            end
            return 1'b0;
        endfunction

        function void push_event(mode_t code, logic last);
            floor_event_t ev;
            ev.code  = code;
            ev.floor = cabin;
            ev.up    = going_up;
            ev.last  = last;
            pending.push_back(ev);
        endfunction

        // open here, or scan ahead, reverse once, then step or rest
        function void resolve();
            bit found;
            found = 1'b0;
            if (called(cabin))
            begin
                mode = MODE_OPENING;
                calls[cabin-1] = 1'b0;
                push_event(MODE_OPENING, 1'b0);
            end
            else
            begin
                for (int pass = 0; pass < 2 && !found; pass++)
                begin
                    found = scan_ahead();
                    if (!found)
                    begin
                        going_up = ~going_up;
                    end
                end
                if (found)
                begin
                    mode  = MODE_RUNNING;
                    cabin = going_up ? cabin + 1'b1 : cabin - 1'b1;
                    push_event(MODE_RUNNING, 1'b0);
                end
                else
                begin
                    mode = MODE_STAYING;
                    push_event(MODE_STAYING, 1'b0);
                end
            end
            push_event(MODE_SOLVING, 1'b1);
        endfunction

        // returns 1 unless the block ignores the transaction
        function bit note_request(req_type_t t, logic [FLOOR_W-1:0] fl);
            case (t)
                REQ_CALL:
                begin
                    if (fl >= 1 && fl <= scan_limit())
                    begin
                        calls[fl-1] = 1'b1;
                        if (mode == MODE_STAYING)
                        begin
                            resolve();
                        end
                        return 1'b1;
                    end
                end
                REQ_CLOSING:
                begin
                    if (mode == MODE_OPENING)
                    begin
                        mode = MODE_CLOSING;
                        push_event(MODE_CLOSING, 1'b1);
                        return 1'b1;
                    end
                end
                default:
                begin
                    if (mode == MODE_STAYING || mode == MODE_CLOSING || mode == MODE_RUNNING)
                    begin
                        resolve();
                        return 1'b1;
                    end
                end
            endcase
            return 1'b0;
        endfunction

        function void match_event(logic [CODE_W-1:0] code, logic [FLOOR_W-1:0] floor,
                                  logic up, logic last);
            floor_event_t want;
            if (pending.size() == 0)
            begin
                $error("unexpected event transaction: event_code %0d, cabin_floor_out %0d",
                       code, floor);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (code !== want.code)
            begin
                $error("event_code mismatch: expected %0d, actual %0d", want.code, code);
                errors++;
            end
            if (floor !== want.floor)
            begin
                $error("cabin_floor_out mismatch: expected %0d, actual %0d", want.floor, floor);
                errors++;
            end
            if (up !== want.up)
            begin
                $error("direction_up mismatch: expected %0d, actual %0d", want.up, up);
                errors++;
            end
            if (last !== want.last)
            begin
                $error("last_of_run mismatch: expected %0d, actual %0d", want.last, last);
                errors++;
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [FLOOR_W-1:0] cfg_data;
    int                 cycle_count = 0;
    int                 burst_left  = 0;

    elevator_tracker tracker;

    esc_req_if req_bus();
    esc_evt_if evt_bus();

    elevator_scan_controller_core uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .req      (req_bus),
        .evt      (evt_bus)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("elevator_scan_controller_core verification failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && evt_bus.valid && evt_bus.ready)
        begin
            tracker.match_event(evt_bus.event_code, evt_bus.cabin_floor_out,
                                evt_bus.direction_up, evt_bus.last_of_run);
        end
    end

    function automatic int idle_span();
        if ($urandom_range(0, 99) < 85)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    // result side: short stalls, a few long ones, and calm stretches
    initial
    begin
        int stall_left;
        int calm_left;
        int r;
        stall_left = 0;
        calm_left  = 0;
        evt_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                evt_bus.ready <= 1'b0;
                stall_left--;
            end
            else if (calm_left > 0)
            begin
                evt_bus.ready <= 1'b1;
                calm_left--;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 5)
                begin
                    calm_left = $urandom_range(50, 200);
                end
                else if (r < 20)
                begin
                    stall_left = idle_span();
                end
                evt_bus.ready <= (r >= 5 && r < 20) ? 1'b0 : 1'b1;
            end
        end
    end

    task automatic issue(input req_type_t t, input logic [FLOOR_W-1:0] fl, output bit effective);
        int gap;
        req_bus.valid      <= 1'b1;
        req_bus.req_type   <= t;
        req_bus.call_floor <= fl;
        @(posedge clk);
        while (!req_bus.ready)
        begin
            @(posedge clk);
        end
        effective = tracker.note_request(t, fl);
        if (burst_left > 0)
        begin
            burst_left--;
            gap = 0;
        end
        else
        begin
            if ($urandom_range(0, 99) < 4)
            begin
                burst_left = $urandom_range(20, 60);
            end
            gap = ($urandom_range(0, 1) == 0) ? 0 : idle_span();
        end
        if (gap > 0)
        begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // hold the sender until every expected result is back and the block is quiet
    task automatic settle();
        req_bus.valid <= 1'b0;
        while (tracker.pending.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_top(input logic [FLOOR_W-1:0] value);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        tracker.top_floor = value;
    endtask

    // mostly events that make sense in the current mode, the rest noise
    task automatic pick_request(output req_type_t t, output logic [FLOOR_W-1:0] fl);
        int r;
        r  = $urandom_range(0, 99);
        fl = FLOOR_W'($urandom_range(1, tracker.scan_limit()));
        if (r < 15)
        begin
            t  = req_type_t'($urandom_range(0, 3));
            fl = FLOOR_W'($urandom_range(0, 31));
        end
        else
        begin
            case (tracker.mode)
                MODE_OPENING: t = (r < 70) ? REQ_CLOSING : REQ_CALL;
                MODE_RUNNING: t = (r < 75) ? REQ_MOVED : REQ_CALL;
                MODE_CLOSING: t = (r < 60) ? REQ_CLOSED : (r < 75) ? REQ_MOVED : REQ_CALL;
                default:      t = (r < 90) ? REQ_CALL : REQ_CLOSED;
            endcase
        end
    endtask

    task automatic run_directed();
        bit eff;
        issue(REQ_CALL, 5'd0, eff);
        issue(REQ_CALL, 5'd31, eff);
        issue(REQ_CALL, 5'd14, eff);
        issue(REQ_MOVED, 5'd0, eff);
        issue(REQ_CLOSING, 5'd0, eff);
        issue(REQ_CLOSED, 5'd0, eff);
        issue(REQ_CALL, 5'd1, eff);
        issue(REQ_CLOSED, 5'd0, eff);
        issue(REQ_CALL, 5'd3, eff);
        issue(REQ_CLOSING, 5'd0, eff);
        issue(REQ_MOVED, 5'd0, eff);
        issue(REQ_CLOSING, 5'd0, eff);
        issue(REQ_MOVED, 5'd0, eff);
        issue(REQ_MOVED, 5'd0, eff);
        issue(REQ_CLOSING, 5'd0, eff);
        issue(REQ_CALL, 5'd1, eff);
        // nothing above, so the scan reverses and heads down
        issue(REQ_CLOSED, 5'd0, eff);
        issue(REQ_MOVED, 5'd0, eff);
        issue(REQ_MOVED, 5'd0, eff);
        issue(REQ_CLOSING, 5'd0, eff);
        issue(REQ_CLOSED, 5'd0, eff);
        issue(REQ_CALL, 5'd13, eff);
        issue(REQ_CALL, 5'd12, eff);
        issue(REQ_MOVED, 5'd30, eff);
    endtask

    initial
    begin
        int                 top_plan[NUM_PHASES];
        int                 done_items;
        bit                 eff;
        req_type_t          t;
        logic [FLOOR_W-1:0] fl;

        top_plan = '{16, 1, 9, 16, 2, 13, 0, 5};
        top_plan[6] = $urandom_range(1, 16);

        rst_n              <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_data           <= '0;
        req_bus.valid      <= 1'b0;
        req_bus.req_type   <= REQ_CALL;
        req_bus.call_floor <= '0;
        tracker = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        settle();

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            write_top(FLOOR_W'(top_plan[phase]));
            done_items = 0;
            while (done_items < PHASE_ITEMS)
            begin
                pick_request(t, fl);
                issue(t, fl, eff);
                if (eff)
                begin
                    done_items++;
                end
                if ($urandom_range(0, 99) == 0)
                begin
                    settle();
                end
            end
            settle();
        end

        if (tracker.errors == 0)
        begin
            $display("elevator_scan_controller_core verification clean");
        end
        else
        begin
            $display("elevator_scan_controller_core verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+rtl/core
rtl/core/esc_pkg.sv
rtl/core/esc_if.sv
rtl/core/esc_datapath.sv
rtl/core/esc_ctrl.sv
rtl/core/elevator_scan_controller_core.sv
dv/tb_elevator_scan_controller_core.sv
